// File: hdl/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared codes and the controller-to-datapath command bundle of the
// counting multiset table.
// ----------------------------------------------------------------------------
package cmt_pkg;

	localparam int KIND_W      = 2;
	localparam int KEY_W       = 32;
	localparam int STATUS_W    = 2;
	localparam int KEY_COUNT_W = 16;
	localparam int TOTAL_W     = 22;

	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [STATUS_W-1:0] status_t;

	// operation codes; the unused code behaves as a lookup
	localparam kind_t KIND_ADD    = 2'd0;
	localparam kind_t KIND_REMOVE = 2'd1;
	localparam kind_t KIND_LOOKUP = 2'd2;

	localparam status_t ST_DONE   = 2'd0;
	localparam status_t ST_ABSENT = 2'd1;
	localparam status_t ST_EMPTY  = 2'd2;
	localparam status_t ST_FULL   = 2'd3;

	typedef struct packed {
		logic load;    // capture the request
		logic look;    // compare all entries, find the free slot
		logic commit;  // update the table and the result register
	} cmd_t;

endpackage

// File: hdl/cmt_ctrl.sv
// ----------------------------------------------------------------------------
// cmt_ctrl
// Sequencer of the counting multiset table: request capture, compare cycle,
// update cycle, and the valid flag of the result register.
// ----------------------------------------------------------------------------
module cmt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output cmt_pkg::cmd_t cmd
);
	import cmt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) || ((state_q == S_UPD) && out_free);
	assign accept   = in_valid && in_ready;

	assign cmd.load   = accept;
	assign cmd.look   = (state_q == S_LOOK);
	assign cmd.commit = (state_q == S_UPD) && out_free;

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = S_LOOK;
			end
			S_LOOK: state_d = S_UPD;
			S_UPD: begin
				// a new request may enter in the cycle the current one commits
				if (out_free)
					state_d = accept ? S_LOOK : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: hdl/cmt_datapath.sv
// ----------------------------------------------------------------------------
// cmt_datapath
// Entry table with per-entry key comparators, lowest-free-slot pick, count
// update and the result register.
// ----------------------------------------------------------------------------
module cmt_datapath #(
	parameter int ENTRIES    = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cmt_pkg::cmd_t                    cmd,
	input  cmt_pkg::kind_t                   kind,
	input  logic signed [cmt_pkg::KEY_W-1:0] key,
	output cmt_pkg::status_t                 status,
	output logic [cmt_pkg::KEY_COUNT_W-1:0]  key_count,
	output logic [cmt_pkg::TOTAL_W-1:0]      total_count
);
	import cmt_pkg::*;

	localparam int CW = (COUNT_BITS > KEY_COUNT_W) ? COUNT_BITS : KEY_COUNT_W;

	// request
	kind_t            kind_q;
	logic [KEY_W-1:0] key_q;

	// table
	logic [KEY_W-1:0]      entry_key_q    [ENTRIES];
	logic [COUNT_BITS-1:0] entry_copies_q [ENTRIES];
	logic [ENTRIES-1:0]    entry_used_q;
	logic [TOTAL_W-1:0]    total_q;

	// compare stage
	logic [ENTRIES-1:0] match_s1;
	logic [ENTRIES-1:0] free_s1;
	logic               any_free_s1;
	logic               empty_s1;
	logic [ENTRIES-1:0] free_vec;

	// update stage
	logic [COUNT_BITS-1:0] hit_cnt;
	logic                  hit;
	logic [ENTRIES-1:0]    wr_sel;
	logic [COUNT_BITS-1:0] new_copies;
	logic                  set_used;
	logic                  clr_used;
	logic                  total_inc;
	logic                  total_dec;
	status_t               res_status;
	logic [COUNT_BITS-1:0] res_cnt;
	logic [CW-1:0]         res_cnt_wide;

	status_t                status_q;
	logic [KEY_COUNT_W-1:0] key_count_q;

	assign free_vec = ~entry_used_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			key_q  <= key;
		end
	end

	// keys are unique among used entries, so match_s1 is one-hot or zero
	always_ff @(posedge clk) begin
		if (cmd.look) begin
			for (int i = 0; i < ENTRIES; i++)
				match_s1[i] <= entry_used_q[i] && (entry_key_q[i] == key_q);
			free_s1     <= free_vec & (~free_vec + ENTRIES'(1));
			any_free_s1 <= |free_vec;
			empty_s1    <= ~|entry_used_q;
		end
	end

	always_comb begin
		hit_cnt = '0;
		for (int i = 0; i < ENTRIES; i++)
			hit_cnt = hit_cnt | (entry_copies_q[i] & {COUNT_BITS{match_s1[i]}});
	end
	assign hit = |match_s1;

	always_comb begin
		wr_sel     = '0;
		new_copies = '0;
		set_used   = 1'b0;
		clr_used   = 1'b0;
		total_inc  = 1'b0;
		total_dec  = 1'b0;
		res_status = ST_DONE;
		res_cnt    = '0;
		case (kind_q)
			KIND_ADD: begin
				if (hit) begin
					res_cnt = hit_cnt;
					if (hit_cnt == '1) begin
						res_status = ST_FULL;
					end else begin
						wr_sel     = match_s1;
						new_copies = hit_cnt + COUNT_BITS'(1);
						res_cnt    = new_copies;
						total_inc  = 1'b1;
					end
				end else if (any_free_s1) begin
					wr_sel     = free_s1;
					new_copies = COUNT_BITS'(1);
					set_used   = 1'b1;
					res_cnt    = COUNT_BITS'(1);
					total_inc  = 1'b1;
				end else begin
					res_status = ST_FULL;
				end
			end
			KIND_REMOVE: begin
				if (empty_s1) begin
					res_status = ST_EMPTY;
				end else if (!hit) begin
					res_status = ST_ABSENT;
				end else begin
					wr_sel     = match_s1;
					new_copies = hit_cnt - COUNT_BITS'(1);
					clr_used   = (hit_cnt == COUNT_BITS'(1));
					res_cnt    = new_copies;
					total_dec  = 1'b1;
				end
			end
			default: begin
				if (hit)
					res_cnt = hit_cnt;
				else
					res_status = ST_ABSENT;
			end
		endcase
	end

	assign res_cnt_wide = CW'(res_cnt);

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (wr_sel[i]) begin
					entry_copies_q[i] <= new_copies;
					if (set_used)
						entry_key_q[i] <= key_q;
				end
			end
			status_q    <= res_status;
			key_count_q <= res_cnt_wide[KEY_COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_used_q <= '0;
			total_q      <= '0;
		end else if (cmd.commit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (wr_sel[i] && set_used)
					entry_used_q[i] <= 1'b1;
				else if (wr_sel[i] && clr_used)
					entry_used_q[i] <= 1'b0;
			end
			if (total_inc)
				total_q <= total_q + TOTAL_W'(1);
			else if (total_dec)
				total_q <= total_q - TOTAL_W'(1);
		end
	end

	assign status      = status_q;
	assign key_count   = key_count_q;
	assign total_count = total_q;

endmodule

// File: hdl/counting_multiset_table.sv
// ----------------------------------------------------------------------------
// counting_multiset_table
// Bag of integer keys with a copy count per key in a table of ENTRIES slots.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready): kind selects add, remove or lookup
//   of one copy of key. Result channel (out_valid/out_ready): status, the
//   key's count after the operation and the total of all counts.
//   Each request gives exactly one result, in order.
//   Flow: after the request transfer, the compare state checks key against
//   every entry and picks the lowest free slot, then the update state
//   updates the table and loads the result register.
//   The single table takes no new request while the current one is in its
//   compare state.
//   The next request is taken in the cycle its predecessor's result is
//   loaded. While a result waits for out_ready, the next request can be
//   taken but stops after its compare cycle until the result transfers.
//   Reset clears all used flags and the total; no clearing pass is needed.
// ----------------------------------------------------------------------------
module counting_multiset_table #(
	parameter int ENTRIES    = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  cmt_pkg::kind_t                   kind,
	input  logic signed [cmt_pkg::KEY_W-1:0] key,
	output logic                             out_valid,
	input  logic                             out_ready,
	output cmt_pkg::status_t                 status,
	output logic [cmt_pkg::KEY_COUNT_W-1:0]  key_count,
	output logic [cmt_pkg::TOTAL_W-1:0]      total_count
);
	import cmt_pkg::*;

	cmd_t cmd;

	cmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	cmt_datapath #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.key         (key),
		.status      (status),
		.key_count   (key_count),
		.total_count (total_count)
	);

	// after a transfer the compare cycle follows, never another transfer
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken during compare cycle");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("commit without result valid");

	a_total_moves_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(total_count))
		else $error("total changed outside commit");

	a_empty_total_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> (total_count == '0) && (key_count == '0))
		else $error("empty bag reported with nonzero counts");

endmodule
